[sv/sspw_pkg.sv]
package sspw_pkg;

    localparam int TEX_MAX_WIDTH  = 80;
    localparam int TEX_MAX_HEIGHT = 48;
    localparam int SCREEN_PITCH   = 320;
    localparam int SCREEN_ROWS    = 200;
    localparam int STORE_DEPTH    = TEX_MAX_WIDTH * TEX_MAX_HEIGHT;

    localparam int TEX_AW  = 12;
    localparam int COL_W   = $clog2(TEX_MAX_WIDTH);
    localparam int ROW_W   = $clog2(TEX_MAX_HEIGHT);
    localparam int COL_LO  = COL_W / 2;
    localparam int ROW_LO  = ROW_W / 2;
    localparam int NUM_W   = 16;
    localparam int DEN_W   = 9;
    localparam int LIN_W   = 18;
    localparam int ADDR_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H    = 3'd4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef struct packed {
        logic [7:0] scale_size;
        logic [8:0] origin_x;
        logic [7:0] origin_y;
        logic [6:0] source_width;
        logic [5:0] source_height;
    } cfg_t;

    typedef struct packed {
        logic              action;
        logic [TEX_AW-1:0] texel_address;
        logic [7:0]        texel_value;
        logic [7:0]        dest_column;
        logic [7:0]        dest_row;
    } item_t;

    typedef struct packed {
        logic              action;
        logic [TEX_AW-1:0] taddr;
        logic [7:0]        tval;
        logic              off;
        logic [ADDR_W-1:0] addr;
    } pass_t;

    typedef struct packed {
        pass_t             p;
        logic [NUM_W-1:0]  num_col;
        logic [NUM_W-1:0]  num_row;
        logic [DEN_W-1:0]  den;
        logic              col_sat;
        logic              row_sat;
    } div_in_t;

    typedef struct packed {
        pass_t             p;
        logic [COL_W-1:0]  scol;
        logic [ROW_W-1:0]  srow;
    } div_out_t;

    typedef struct packed {
        logic [ADDR_W-1:0] buffer_address;
        logic [7:0]        pixel_value;
        logic              write_enable;
        logic              off_screen;
    } result_t;

endpackage

[sv/sspw_front.sv]
module sspw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sspw_pkg::item_t   in_item,
    input  sspw_pkg::cfg_t    cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output sspw_pkg::div_in_t out_data
);
    import sspw_pkg::*;

    typedef struct packed {
        logic              action;
        logic [TEX_AW-1:0] taddr;
        logic [7:0]        tval;
        logic [NUM_W-1:0]  num_col;
        logic [NUM_W-1:0]  num_row;
        logic [DEN_W-1:0]  den;
        logic [8:0]        ysum;
        logic [9:0]        xsum;
    } front_a_t;

    front_a_t         a_reg;
    front_a_t         a_next;
    logic             a_valid_reg;
    logic             a_en;
    div_in_t          b_reg;
    div_in_t          b_next;
    logic             b_valid_reg;
    logic             b_en;

    logic [7:0]       s_eff;
    logic [8:0]       col1;
    logic [8:0]       row1;
    logic [NUM_W-1:0] prod_col;
    logic [NUM_W-1:0] prod_row;
    logic [LIN_W-1:0] lin;
    logic [NUM_W:0]   lim_col;
    logic [NUM_W:0]   lim_row;
    logic             off;

    assign b_en     = !b_valid_reg || out_ready;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // Rounded mapping numerator: 2*(pos+1)*extent + scale, over 2*scale.
    always_comb
    begin
        s_eff    = (cfg.scale_size == 8'd0) ? 8'd1 : cfg.scale_size;
        col1     = {1'b0, in_item.dest_column} + 9'd1;
        row1     = {1'b0, in_item.dest_row} + 9'd1;
        prod_col = NUM_W'({col1, 1'b0}) * NUM_W'(cfg.source_width);
        prod_row = NUM_W'({row1, 1'b0}) * NUM_W'(cfg.source_height);

        a_next.action  = in_item.action;
        a_next.taddr   = in_item.texel_address;
        a_next.tval    = in_item.texel_value;
        a_next.num_col = prod_col + NUM_W'(s_eff);
        a_next.num_row = prod_row + NUM_W'(s_eff);
        a_next.den     = {1'b0, s_eff} << 1;
        a_next.ysum    = 9'(cfg.origin_y) + 9'(in_item.dest_row);
        a_next.xsum    = 10'(cfg.origin_x) + 10'(in_item.dest_column);
    end

    always_comb
    begin
        lin     = LIN_W'(a_reg.ysum) * LIN_W'(SCREEN_PITCH) + LIN_W'(a_reg.xsum);
        off     = lin >= LIN_W'(SCREEN_PITCH * SCREEN_ROWS);
        lim_col = (NUM_W+1)'(a_reg.den) * (NUM_W+1)'(TEX_MAX_WIDTH);
        lim_row = (NUM_W+1)'(a_reg.den) * (NUM_W+1)'(TEX_MAX_HEIGHT);

        b_next.p.action = a_reg.action;
        b_next.p.taddr  = a_reg.taddr;
        b_next.p.tval   = a_reg.tval;
        b_next.p.off    = off;
        b_next.p.addr   = off ? '0 : lin[ADDR_W-1:0];
        b_next.num_col  = a_reg.num_col;
        b_next.num_row  = a_reg.num_row;
        b_next.den      = a_reg.den;
        b_next.col_sat  = {1'b0, a_reg.num_col} >= lim_col;
        b_next.row_sat  = {1'b0, a_reg.num_row} >= lim_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_reg <= a_next;
        end
        if (b_en)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

[sv/sspw_div.sv]
module sspw_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sspw_pkg::div_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sspw_pkg::div_out_t out_data
);
    import sspw_pkg::*;

    typedef struct packed {
        pass_t             p;
        logic [NUM_W-1:0]  rem_col;
        logic [NUM_W-1:0]  rem_row;
        logic [COL_W-1:0]  q_col;
        logic [ROW_W-1:0]  q_row;
        logic [DEN_W-1:0]  den;
        logic              col_sat;
        logic              row_sat;
    } div_mid_t;

    div_mid_t c_reg;
    div_mid_t c_next;
    logic     c_valid_reg;
    logic     c_en;
    div_out_t d_reg;
    div_out_t d_next;
    logic     d_valid_reg;
    logic     d_en;

    assign d_en     = !d_valid_reg || out_ready;
    assign c_en     = !c_valid_reg || d_en;
    assign in_ready = c_en;

    // Restoring division, upper quotient bits. A saturated lane is clamped
    // later, so its quotient bits do not matter.
    always_comb
    begin
        logic [NUM_W:0] rc;
        logic [NUM_W:0] rr;
        logic [NUM_W:0] trial;
        rc           = {1'b0, in_data.num_col};
        rr           = {1'b0, in_data.num_row};
        c_next.q_col = '0;
        c_next.q_row = '0;
        for (int i = COL_W - 1; i >= COL_LO; i--)
        begin
            trial = (NUM_W+1)'(in_data.den) << i;
            if (rc >= trial)
            begin
                rc              = rc - trial;
                c_next.q_col[i] = 1'b1;
            end
        end
        for (int i = ROW_W - 1; i >= ROW_LO; i--)
        begin
            trial = (NUM_W+1)'(in_data.den) << i;
            if (rr >= trial)
            begin
                rr              = rr - trial;
                c_next.q_row[i] = 1'b1;
            end
        end
        c_next.p       = in_data.p;
        c_next.rem_col = rc[NUM_W-1:0];
        c_next.rem_row = rr[NUM_W-1:0];
        c_next.den     = in_data.den;
        c_next.col_sat = in_data.col_sat;
        c_next.row_sat = in_data.row_sat;
    end

    always_comb
    begin
        logic [NUM_W:0]   rc;
        logic [NUM_W:0]   rr;
        logic [NUM_W:0]   trial;
        logic [COL_W-1:0] qc;
        logic [ROW_W-1:0] qr;
        rc = {1'b0, c_reg.rem_col};
        rr = {1'b0, c_reg.rem_row};
        qc = c_reg.q_col;
        qr = c_reg.q_row;
        for (int i = COL_LO - 1; i >= 0; i--)
        begin
            trial = (NUM_W+1)'(c_reg.den) << i;
            if (rc >= trial)
            begin
                rc    = rc - trial;
                qc[i] = 1'b1;
            end
        end
        for (int i = ROW_LO - 1; i >= 0; i--)
        begin
            trial = (NUM_W+1)'(c_reg.den) << i;
            if (rr >= trial)
            begin
                rr    = rr - trial;
                qr[i] = 1'b1;
            end
        end
        d_next.p    = c_reg.p;
        d_next.scol = c_reg.col_sat ? COL_W'(TEX_MAX_WIDTH - 1) : qc;
        d_next.srow = c_reg.row_sat ? ROW_W'(TEX_MAX_HEIGHT - 1) : qr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_en)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_en)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en)
        begin
            c_reg <= c_next;
        end
        if (d_en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_reg;

endmodule

[sv/sspw_tex.sv]
module sspw_tex (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sspw_pkg::div_out_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sspw_pkg::result_t  out_data
);
    import sspw_pkg::*;

    div_out_t          e_reg;
    logic              e_valid_reg;
    logic              e_en;
    logic              f_valid_reg;
    logic              f_en;
    logic [ADDR_W-1:0] f_addr_reg;
    logic              f_off_reg;
    logic [7:0]        pix_reg;
    logic [TEX_AW-1:0] rd_idx;
    logic              wr_en;

    logic [7:0] tex_mem [STORE_DEPTH];

    assign f_en     = !f_valid_reg || out_ready;
    assign e_en     = !e_valid_reg || f_en;
    assign in_ready = e_en;

    assign rd_idx = TEX_AW'(e_reg.srow) * TEX_AW'(TEX_MAX_WIDTH) + TEX_AW'(e_reg.scol);
    assign wr_en  = e_valid_reg && (e_reg.p.action == ACT_LOAD) && f_en
                    && (e_reg.p.taddr < TEX_AW'(STORE_DEPTH));

    // Loads write as they leave this stage, so a later draw always sees them.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tex_mem[e_reg.p.taddr] <= e_reg.p.tval;
        end
        if (f_en)
        begin
            pix_reg <= tex_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_en)
            begin
                e_valid_reg <= in_valid;
            end
            if (f_en)
            begin
                f_valid_reg <= e_valid_reg && (e_reg.p.action == ACT_DRAW);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_en)
        begin
            e_reg <= in_data;
        end
        if (f_en)
        begin
            f_addr_reg <= e_reg.p.addr;
            f_off_reg  <= e_reg.p.off;
        end
    end

    assign out_valid               = f_valid_reg;
    assign out_data.buffer_address = f_addr_reg;
    assign out_data.pixel_value    = pix_reg;
    assign out_data.write_enable   = (pix_reg != 8'd0) && !f_off_reg;
    assign out_data.off_screen     = f_off_reg;

endmodule

[sv/scaled_sprite_pixel_writer_core.sv]
// Channel   Side    Beat contents
// s_axis    input   one load or draw item, action in tuser
// m_axis    output  one frame-buffer write per draw
// cfg       input   register write, no read-back
//
// One beat is taken every cycle unless a stalled output has filled the pipeline.
// A draw reaches m_axis through the stages numerator, clamp and screen address,
// two halves of the restoring divider, texel index, and the texture read.
// Loads update the texture when they leave the index stage and give no beat.
// Reset clears valid bits and the cfg registers; data and texture are not cleared.
// A stalled output fills the pipeline stage by stage; bubbles close up.
module scaled_sprite_pixel_writer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // texel_address, texel_value, dest_column, dest_row
    input  logic [39:0]                         s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // buffer_address, pixel_value, write_enable, off_screen
    output logic [31:0]                         m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [sspw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sspw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sspw_pkg::*;

    cfg_t      cfg_reg;
    item_t     item;
    div_in_t   front_data;
    logic      front_valid;
    logic      front_ready;
    div_out_t  div_data;
    logic      div_valid;
    logic      div_ready;
    result_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_size    <= 8'd64;
            cfg_reg.origin_x      <= 9'd0;
            cfg_reg.origin_y      <= 8'd0;
            cfg_reg.source_width  <= 7'd80;
            cfg_reg.source_height <= 6'd48;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SCALE:    cfg_reg.scale_size    <= cfg_data[7:0];
                REG_ORIGIN_X: cfg_reg.origin_x      <= cfg_data[8:0];
                REG_ORIGIN_Y: cfg_reg.origin_y      <= cfg_data[7:0];
                REG_SRC_W:    cfg_reg.source_width  <= cfg_data[6:0];
                REG_SRC_H:    cfg_reg.source_height <= cfg_data[5:0];
                default:      ;
            endcase
        end
    end

    assign item.action        = s_axis_tuser;
    assign item.texel_address = s_axis_tdata[11:0];
    assign item.texel_value   = s_axis_tdata[19:12];
    assign item.dest_column   = s_axis_tdata[27:20];
    assign item.dest_row      = s_axis_tdata[35:28];

    sspw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (item),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    sspw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    sspw_tex u_tex (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {6'd0, res.off_screen, res.write_enable,
                           res.pixel_value, res.buffer_address};

endmodule

[sv/sspw_checker.sv]
module sspw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_off_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[25] |-> !m_axis_tdata[24] && m_axis_tdata[15:0] == 16'd0)
        else $error("off-screen beat carries a write or an address");

    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[23:16] != 8'd0)
        else $error("write enabled for a transparent texel");

    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] < 16'd64000 && m_axis_tdata[31:26] == 6'd0)
        else $error("buffer address beyond the screen or padding set");

endmodule

bind scaled_sprite_pixel_writer_core sspw_checker u_sspw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
